// ===== rtl/sorted_set_table_defines.svh =====
// Assertion macros for the sorted set table.
`ifndef SORTED_SET_TABLE_DEFINES_SVH
`define SORTED_SET_TABLE_DEFINES_SVH

// Concurrent check on clk, off while in reset.
`define SST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check on clk, off while in reset.
`define SST_ASSERT_IMPL(label, ante, cons, msg) \
    `SST_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/sst_pkg.sv =====
// Shared types and constants for the sorted set table.
package sst_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GROUP_N  = 8;
    localparam int GROUPS   = (CAPACITY + GROUP_N - 1) / GROUP_N;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_RESERVED = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_REDUCE,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic               compare;
        logic               ins;
        logic               del;
        logic signed [31:0] value;
    } cell_ctrl_t;

endpackage

// ===== rtl/sst_cell.sv =====
// One compare-and-shift cell of the sorted element chain.
module sst_cell
    import sst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic               occupied,
    input  logic signed [31:0] left_elem,
    input  logic               left_lt,
    input  logic signed [31:0] right_elem,
    output logic signed [31:0] elem,
    output logic               lt,
    output logic               eq
);

    logic signed [31:0] elem_reg;
    logic signed [31:0] elem_next;
    logic               lt_reg;
    logic               lt_next;
    logic               eq_reg;
    logic               eq_next;

    always_comb
    begin
        lt_next   = lt_reg;
        eq_next   = eq_reg;
        elem_next = elem_reg;
        if (ctrl.compare)
        begin
            lt_next = occupied && (elem_reg < ctrl.value);
            eq_next = occupied && (elem_reg == ctrl.value);
        end
        if (ctrl.ins && !lt_reg)
        begin
            elem_next = left_lt ? ctrl.value : left_elem;
        end
        else if (ctrl.del && !lt_reg)
        begin
            elem_next = right_elem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    assign elem = elem_reg;
    assign lt   = lt_reg;
    assign eq   = eq_reg;

endmodule

// ===== rtl/sst_match_reduce.sv =====
// Registered OR tree over the cell match flags.
module sst_match_reduce
    import sst_pkg::*;
(
    input  logic                clk,
    input  logic [CAPACITY-1:0] match,
    output logic                any_match
);

    logic [GROUPS*GROUP_N-1:0] padded;
    logic [GROUPS-1:0]         group_reg;
    logic [GROUPS-1:0]         group_next;

    assign padded = (GROUPS*GROUP_N)'(match);

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            group_next[g] = |padded[g*GROUP_N +: GROUP_N];
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
    end

    assign any_match = |group_reg;

endmodule

// ===== rtl/sorted_set_table.sv =====
// Sorted set table: top level with command sequencer and cell chain.
//
// Holds up to CAPACITY distinct signed 32-bit values in ascending order.
// A command is taken when start is high and busy is low. Its result appears
// on was_present, element_count and add_dropped, with done high for exactly
// one cycle; the receiver cannot stall it, so it must sample on that strobe.
// Each command passes through the cells comparing against the value, the
// registered match OR tree and the cells shifting, then returns to idle; busy
// is high until then, so no new command is taken before the last one is done.
module sorted_set_table
    import sst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic signed [31:0] value,
    output logic               done,
    output logic               was_present,
    output logic [6:0]         element_count,
    output logic               add_dropped
);

`include "sorted_set_table_defines.svh"

    state_t             state_reg;
    state_t             state_next;
    logic [1:0]         cmd_reg;
    logic signed [31:0] value_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    logic               done_next;
    logic               present_reg;
    logic               dropped_reg;
    logic               dropped_next;

    cell_ctrl_t         ctrl;
    logic               accept;
    logic               present;
    logic [CNT_W+6:0]   count_ext;

    logic signed [31:0] elem [CAPACITY];
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] occ_vec;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    sst_match_reduce u_reduce
    (
        .clk       (clk),
        .match     (eq_vec),
        .any_match (present)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign occ_vec[i] = (CNT_W'(i) < count_reg);
        sst_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .occupied   (occ_vec[i]),
            .left_elem  ((i == 0) ? value_reg : elem[(i == 0) ? 0 : i - 1]),
            .left_lt    ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]),
            .right_elem (elem[(i == CAPACITY - 1) ? i : i + 1]),
            .elem       (elem[i]),
            .lt         (lt_vec[i]),
            .eq         (eq_vec[i])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        dropped_next = 1'b0;
        ctrl.compare = 1'b0;
        ctrl.ins     = 1'b0;
        ctrl.del     = 1'b0;
        ctrl.value   = value_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                ctrl.compare = 1'b1;
                state_next   = S_REDUCE;
            end
            S_REDUCE:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (!present)
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                ctrl.ins   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (present)
                        begin
                            ctrl.del   = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            value_reg <= value;
        end
        if (state_reg == S_APPLY)
        begin
            present_reg <= present;
            dropped_reg <= dropped_next;
        end
    end

    assign count_ext     = {7'd0, count_reg};
    assign done          = done_reg;
    assign was_present   = present_reg;
    assign element_count = count_ext[6:0];
    assign add_dropped   = dropped_reg;

    `SST_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SST_ASSERT_IMPL(a_done_after_apply, done_reg, $past(state_reg == S_APPLY),
                     "result strobe without apply step")
    `SST_ASSERT_IMPL(a_drop_full, done_reg && dropped_reg,
                     !present_reg && (count_reg == CNT_W'(CAPACITY)),
                     "add dropped while not full or value present")
    `SST_ASSERT_IMPL(a_count_step, state_reg != S_APPLY, count_next == count_reg,
                     "count changed outside apply step")

endmodule

// ===== tb/tb_sorted_set_table.sv =====
// Testbench for sorted_set_table: random add/remove/lookup commands checked against a set model.
`timescale 1ns / 100ps

module tb_sorted_set_table;
    import sst_pkg::*;

    localparam int N_RANDOM    = 1430;
    localparam int POOL_N      = 100;
    localparam int QUIET_LIMIT = 1000;
    localparam int CALM_TAIL   = 150;

    typedef struct {
        command_t           cmd;
        logic signed [31:0] val;
    } set_cmd_t;

    typedef struct {
        logic       was_present;
        logic [6:0] count;
        logic       dropped;
    } set_reply_t;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    logic [1:0]         command = CMD_ADD;
    logic signed [31:0] value   = '0;
    logic               busy;
    logic               done;
    logic               was_present;
    logic [6:0]         element_count;
    logic               add_dropped;

    always #5 clk = ~clk;

    sorted_set_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .value         (value),
        .done          (done),
        .was_present   (was_present),
        .element_count (element_count),
        .add_dropped   (add_dropped)
    );

    set_cmd_t           cmd_queue[$];
    set_reply_t         reply_queue[$];
    logic signed [31:0] model_elems[CAPACITY];
    logic signed [31:0] pool[POOL_N];
    int                 model_len  = 0;
    int                 errors     = 0;
    int                 n_add      = 0;
    int                 n_remove   = 0;
    int                 n_query    = 0;
    int                 n_refused  = 0;
    int                 n_checked  = 0;
    int                 peak_len   = 0;
    int                 gap_left   = 0;
    int                 quiet      = 0;
    bit                 idle_on    = 1'b1;

    // Ordered set update in true signed order.
    function automatic set_reply_t apply_set_op(command_t cmd, logic signed [31:0] v);
        set_reply_t r;
        int         pos;
        bit         hit;
        pos = 0;
        while (pos < model_len && model_elems[pos] < v)
            pos++;
        hit = (pos < model_len) && (model_elems[pos] == v);
        r.dropped = 1'b0;
        if (cmd == CMD_ADD && !hit)
        begin
            if (model_len >= CAPACITY)
                r.dropped = 1'b1;
            else
            begin
                for (int j = model_len; j > pos; j--)
                    model_elems[j] = model_elems[j - 1];
                model_elems[pos] = v;
                model_len++;
            end
        end
        else if (cmd == CMD_REMOVE && hit)
        begin
            for (int j = pos; j + 1 < model_len; j++)
                model_elems[j] = model_elems[j + 1];
            model_len--;
        end
        r.was_present = hit;
        r.count       = model_len[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic push_cmd(command_t c, logic signed [31:0] v);
        set_cmd_t item;
        item.cmd = c;
        item.val = v;
        cmd_queue.push_back(item);
    endtask

    // Driver: one command per transfer, random idle bursts until the tail.
    always @(posedge clk)
    begin
        set_reply_t exp_r;
        set_cmd_t   nxt;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                exp_r = apply_set_op(command_t'(command), value);
                reply_queue.push_back(exp_r);
                case (command_t'(command))
                    CMD_ADD:    n_add++;
                    CMD_REMOVE: n_remove++;
                    default:    n_query++;
                endcase
                if (exp_r.dropped)
                    n_refused++;
                if (model_len > peak_len)
                    peak_len = model_len;
                if (cmd_queue.size() < CALM_TAIL)
                    idle_on = 1'b0;
                else if ($urandom_range(0, 99) < 4)
                    idle_on = !idle_on;
                if (idle_on && $urandom_range(0, 99) < 25)
                    gap_left = $urandom_range(1, 18);
            end
            if (start && busy)
            begin
                // hold the command until the block takes it
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                nxt = cmd_queue.pop_front();
                start   <= 1'b1;
                command <= nxt.cmd;
                value   <= nxt.val;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: results come on the done strobe and cannot be held off.
    always @(posedge clk)
    begin
        set_reply_t exp_r;
        if (rst_n && done)
        begin
            if (reply_queue.size() == 0)
                report_mismatch("result strobe with no command outstanding");
            else
            begin
                exp_r = reply_queue.pop_front();
                if (was_present !== exp_r.was_present)
                    report_mismatch($sformatf("reply %0d was_present got %b want %b",
                        n_checked, was_present, exp_r.was_present));
                if (element_count !== exp_r.count)
                    report_mismatch($sformatf("reply %0d element_count got %0d want %0d",
                        n_checked, element_count, exp_r.count));
                if (add_dropped !== exp_r.dropped)
                    report_mismatch($sformatf("reply %0d add_dropped got %b want %b",
                        n_checked, add_dropped, exp_r.dropped));
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Watchdog: no transfer or result for %0d cycles", quiet);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int                 made;
        int                 kind;
        int                 len;
        int                 r;
        command_t           c;
        logic signed [31:0] v;

        pool[0] = 32'sh8000_0000;
        pool[1] = 32'sh7fff_ffff;
        pool[2] = 32'sh0000_0000;
        pool[3] = -32'sd1;
        pool[4] = 32'sd1;
        pool[5] = 32'sh8000_0001;
        pool[6] = 32'sh7fff_fffe;
        pool[7] = 32'sd2;
        for (int i = 8; i < POOL_N; i++)
        begin
            if (i % 4 == 0)
                pool[i] = pool[i - 1] + 32'sd1;
            else
                pool[i] = $urandom;
        end

        push_cmd(CMD_CONTAINS, 32'sd0);
        push_cmd(CMD_REMOVE,   32'sd5);
        push_cmd(CMD_ADD,      32'sd0);
        push_cmd(CMD_ADD,      32'sh7fff_ffff);
        push_cmd(CMD_ADD,      32'sh8000_0000);
        push_cmd(CMD_ADD,      -32'sd1);
        push_cmd(CMD_ADD,      32'sd1);
        push_cmd(CMD_ADD,      32'sd0);
        push_cmd(CMD_CONTAINS, 32'sh8000_0000);
        push_cmd(CMD_CONTAINS, 32'sh7fff_ffff);
        push_cmd(CMD_CONTAINS, 32'sd2);
        push_cmd(CMD_RESERVED, 32'sd1);
        push_cmd(CMD_RESERVED, 32'sd3);
        push_cmd(CMD_REMOVE,   32'sh8000_0000);
        push_cmd(CMD_REMOVE,   32'sh7fff_ffff);
        push_cmd(CMD_REMOVE,   32'sd0);
        push_cmd(CMD_REMOVE,   32'sd0);
        push_cmd(CMD_ADD,      32'sh7fff_fffe);
        push_cmd(CMD_ADD,      32'sh8000_0001);
        push_cmd(CMD_REMOVE,   -32'sd1);
        push_cmd(CMD_REMOVE,   32'sd1);
        push_cmd(CMD_REMOVE,   32'sh7fff_fffe);
        push_cmd(CMD_REMOVE,   32'sh8000_0001);

        // Phases: fill toward full, drain, mixed, and raw noise.
        made = 0;
        while (made < N_RANDOM)
        begin
            kind = $urandom_range(0, 3);
            len  = $urandom_range(60, 200);
            if (kind == 3)
                len = len / 4;
            for (int k = 0; k < len && made < N_RANDOM; k++)
            begin
                r = $urandom_range(0, 99);
                case (kind)
                    0:       c = (r < 75) ? CMD_ADD : (r < 85) ? CMD_REMOVE :
                                 (r < 95) ? CMD_CONTAINS : CMD_RESERVED;
                    1:       c = (r < 5) ? CMD_ADD : (r < 80) ? CMD_REMOVE :
                                 (r < 95) ? CMD_CONTAINS : CMD_RESERVED;
                    2:       c = (r < 40) ? CMD_ADD : (r < 70) ? CMD_REMOVE :
                                 (r < 95) ? CMD_CONTAINS : CMD_RESERVED;
                    default: c = command_t'($urandom_range(0, 3));
                endcase
                if (kind == 3 || $urandom_range(0, 9) == 0)
                    v = $urandom;
                else
                    v = pool[$urandom_range(0, POOL_N - 1)];
                push_cmd(c, v);
                made++;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (cmd_queue.size() != 0 || start || reply_queue.size() != 0);
        repeat (8) @(posedge clk);

        $display("Covered %0d commands: %0d add, %0d remove, %0d lookup; %0d results checked",
            n_add + n_remove + n_query, n_add, n_remove, n_query, n_checked);
        $display("Table reached %0d elements; %0d adds refused on a full table",
            peak_len, n_refused);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
